FILE: design/lpg_pkg.sv
// Shared types and constants for the line pixel generator.
// No dependencies; imported by lpg_step, lpg_addr and the top level.
package lpg_pkg;

	localparam int PIX_W   = 12;
	localparam int ADDR_W  = 24;
	localparam int COLOR_W = 32;
	localparam int RW_W    = 13;

	localparam logic [RW_W-1:0] RW_RESET = 13'd640;

	localparam int OUT_DATA_W = 2*PIX_W + ADDR_W + COLOR_W;

	typedef enum logic {
		REQ_START = 1'b0,
		REQ_STEP  = 1'b1
	} req_t;

	// Control travelling alongside a pixel through the back stages
	typedef struct packed {
		logic valid;
		logic pixel_valid;
		logic last;
	} pix_ctl_t;

endpackage

FILE: design/lpg_skid.sv
// Input register with a one-entry skid buffer for the request stream.
// Depends on nothing but the stage-advance enable from the output side.
module lpg_skid #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] in_data,
	output logic         valid_s1,
	output logic [W-1:0] data_s1
);

	logic         skid_valid_q;
	logic [W-1:0] skid_data_q;
	logic         accept;

	assign in_ready = !skid_valid_q;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_valid_q <= 1'b0;
			valid_s1     <= 1'b0;
		end else if (en) begin
			skid_valid_q <= 1'b0;
			valid_s1     <= skid_valid_q || accept;
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= skid_valid_q ? skid_data_q : in_data;
		end
		if (!en && accept) begin
			skid_data_q <= in_data;
		end
	end

endmodule

FILE: design/lpg_step.sv
// Line state and single-pixel step: start set-up, error update, minor-axis step.
// Depends on lpg_pkg; feeds the address stage with one result per request.
module lpg_step #(
	parameter int CB = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  item_valid,
	input  lpg_pkg::req_t         req_type,
	input  logic [CB-1:0]         start_x,
	input  logic [CB-1:0]         start_y,
	input  logic [CB-1:0]         end_x,
	input  logic [CB-1:0]         end_y,
	input  logic [lpg_pkg::COLOR_W-1:0] line_color,
	output lpg_pkg::pix_ctl_t     ctl_s2,
	output logic [CB-1:0]         x_s2,
	output logic [CB-1:0]         y_s2,
	output logic [lpg_pkg::COLOR_W-1:0] color_s2
);
	import lpg_pkg::*;

	logic [CB-1:0]      cur_x_q, cur_y_q, major_q, minor_q, steps_q;
	logic [CB:0]        err_q;
	logic               x_neg_q, y_neg_q, x_major_q, busy_q;
	logic [COLOR_W-1:0] color_q;

	// start set-up
	logic          x_pos, y_pos, st_x_major;
	logic [CB-1:0] adx, ady, st_major, st_minor;

	// step
	logic [CB+1:0] err_sum;
	logic          wrap;
	logic [CB+1:0] err_red;
	logic [CB-1:0] x_stepped, y_stepped, nx, ny, steps_nx;

	always_comb begin
		x_pos      = end_x > start_x;
		y_pos      = end_y > start_y;
		adx        = x_pos ? end_x - start_x : start_x - end_x;
		ady        = y_pos ? end_y - start_y : start_y - end_y;
		st_x_major = adx > ady;
		st_major   = st_x_major ? adx : ady;
		st_minor   = st_x_major ? ady : adx;

		err_sum   = (CB+2)'(err_q) + (CB+2)'(minor_q);
		wrap      = err_sum >= (CB+2)'(major_q);
		err_red   = wrap ? err_sum - (CB+2)'(major_q) : err_sum;
		x_stepped = x_neg_q ? cur_x_q - CB'(1) : cur_x_q + CB'(1);
		y_stepped = y_neg_q ? cur_y_q - CB'(1) : cur_y_q + CB'(1);
		if (x_major_q) begin
			nx = x_stepped;
			ny = wrap ? y_stepped : cur_y_q;
		end else begin
			ny = y_stepped;
			nx = wrap ? x_stepped : cur_x_q;
		end
		steps_nx = steps_q - CB'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q   <= '0;
			cur_y_q   <= '0;
			err_q     <= '0;
			major_q   <= '0;
			minor_q   <= '0;
			steps_q   <= '0;
			x_neg_q   <= 1'b0;
			y_neg_q   <= 1'b0;
			x_major_q <= 1'b0;
			busy_q    <= 1'b0;
			color_q   <= '0;
			ctl_s2    <= '0;
		end else if (en) begin
			ctl_s2.valid       <= item_valid;
			ctl_s2.pixel_valid <= 1'b0;
			ctl_s2.last        <= 1'b0;
			if (item_valid) begin
				unique case (req_type)
					REQ_START: begin
						x_neg_q            <= !x_pos;
						y_neg_q            <= !y_pos;
						x_major_q          <= st_x_major;
						major_q            <= st_major;
						minor_q            <= st_minor;
						err_q              <= (CB+1)'(st_major >> 1);
						steps_q            <= st_major;
						cur_x_q            <= start_x;
						cur_y_q            <= start_y;
						color_q            <= line_color;
						busy_q             <= st_major != '0;
						ctl_s2.pixel_valid <= 1'b1;
						ctl_s2.last        <= st_major == '0;
					end
					REQ_STEP: begin
						if (busy_q) begin
							err_q              <= err_red[CB:0];
							cur_x_q            <= nx;
							cur_y_q            <= ny;
							steps_q            <= steps_nx;
							busy_q             <= steps_nx != '0;
							ctl_s2.pixel_valid <= 1'b1;
							ctl_s2.last        <= steps_nx == '0;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2     <= '0;
			y_s2     <= '0;
			color_s2 <= '0;
			if (item_valid) begin
				if (req_type == REQ_START) begin
					x_s2     <= start_x;
					y_s2     <= start_y;
					color_s2 <= line_color;
				end else if (busy_q) begin
					x_s2     <= nx;
					y_s2     <= ny;
					color_s2 <= color_q;
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_err_below_major: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (err_q < (CB+1)'(major_q)))
		else $error("error term not below major length");
	a_minor_le_major: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (minor_q <= major_q))
		else $error("minor length exceeds major length");
	a_busy_steps: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (steps_q != '0))
		else $error("line busy with no steps left");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s2.valid && ctl_s2.last) |-> !busy_q)
		else $error("last pixel emitted while line still busy");
`endif

endmodule

FILE: design/lpg_addr.sv
// Frame-buffer address multiply-add and output register.
// Depends on lpg_pkg; produces the stage-advance enable for the whole pipe.
module lpg_addr #(
	parameter int CB = 12
) (
	input  logic                           clk,
	input  logic                           arst_n,
	output logic                           en,
	input  lpg_pkg::pix_ctl_t              ctl_s2,
	input  logic [CB-1:0]                  x_s2,
	input  logic [CB-1:0]                  y_s2,
	input  logic [lpg_pkg::COLOR_W-1:0]    color_s2,
	input  logic [lpg_pkg::RW_W-1:0]       row_width,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [lpg_pkg::OUT_DATA_W-1:0] out_data,
	output logic                           out_user,
	output logic                           out_last
);
	import lpg_pkg::*;

	localparam int SUM_W = CB + RW_W + 1;

	logic [SUM_W-1:0] addr_full;

	assign en        = !out_valid || out_ready;
	assign addr_full = SUM_W'(y_s2) * SUM_W'(row_width) + SUM_W'(x_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= ctl_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_user <= ctl_s2.pixel_valid;
			out_last <= ctl_s2.last;
			out_data <= {color_s2, ADDR_W'(addr_full), PIX_W'(y_s2), PIX_W'(x_s2)};
		end
	end

endmodule

FILE: design/line_pixel_generator.sv
// Line pixel generator top level: config register, input buffer, step and address stages.
// Depends on lpg_pkg, lpg_skid, lpg_step and lpg_addr.
//
// Bresenham line rasteriser. A start request (tuser 0) loads both endpoints and
// the colour and returns the first pixel; each step request (tuser 1) returns
// the next pixel, with tlast on the final endpoint. A step while no line is
// running returns a result with pixel_valid low and all fields zero. One
// request is taken and one result given every clock while the result side
// does not stall; each request passes through the input register, then the
// step stage, then the address stage output register, and a stall on the
// result side holds the pipe with one request held in the input skid buffer.
// The user must write row_width only while idle; the block does not enforce it.
module line_pixel_generator #(
	parameter int COORD_BITS = 12
) (
	input  logic clk,
	input  logic arst_n,
	// request stream
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// tdata: start_x, start_y, end_x, end_y, line_color, zero padding
	input  logic [((4*COORD_BITS+lpg_pkg::COLOR_W+7)/8)*8-1:0] s_axis_tdata,
	// tuser: req_type
	input  logic s_axis_tuser,
	// pixel stream
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// tdata: pixel_x, pixel_y, pixel_address, pixel_color
	output logic [lpg_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// tuser: pixel_valid
	output logic m_axis_tuser,
	output logic m_axis_tlast,
	// row_width write
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [lpg_pkg::RW_W-1:0] cfg_data
);
	import lpg_pkg::*;

	localparam int IN_W = 1 + 4*COORD_BITS + COLOR_W;

	logic [RW_W-1:0]          row_width_q;
	logic                     en;
	logic                     valid_s1;
	logic [IN_W-1:0]          data_s1;
	pix_ctl_t                 ctl_s2;
	logic [COORD_BITS-1:0]    x_s2, y_s2;
	logic [COLOR_W-1:0]       color_s2;
	req_t                     req_s1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= RW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			row_width_q <= cfg_data;
		end
	end

	lpg_skid #(
		.W(IN_W)
	) u_skid (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_data ({s_axis_tdata[4*COORD_BITS+COLOR_W-1:0], s_axis_tuser}),
		.valid_s1(valid_s1),
		.data_s1 (data_s1)
	);

	assign req_s1 = req_t'(data_s1[0]);

	lpg_step #(
		.CB(COORD_BITS)
	) u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.item_valid(valid_s1),
		.req_type  (req_s1),
		.start_x   (data_s1[1 +: COORD_BITS]),
		.start_y   (data_s1[1+COORD_BITS +: COORD_BITS]),
		.end_x     (data_s1[1+2*COORD_BITS +: COORD_BITS]),
		.end_y     (data_s1[1+3*COORD_BITS +: COORD_BITS]),
		.line_color(data_s1[1+4*COORD_BITS +: COLOR_W]),
		.ctl_s2    (ctl_s2),
		.x_s2      (x_s2),
		.y_s2      (y_s2),
		.color_s2  (color_s2)
	);

	lpg_addr #(
		.CB(COORD_BITS)
	) u_addr (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.ctl_s2   (ctl_s2),
		.x_s2     (x_s2),
		.y_s2     (y_s2),
		.color_s2 (color_s2),
		.row_width(row_width_q),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (m_axis_tdata),
		.out_user (m_axis_tuser),
		.out_last (m_axis_tlast)
	);

endmodule

FILE: dv/line_pixel_generator_test.sv
// Self-checking testbench for line_pixel_generator: stream driver, stall pattern, pixel checker.
// Depends on lpg_pkg and the line_pixel_generator RTL; needs no other files.
// Expected pixels are worked out by an in-bench Bresenham stepper fed from accepted requests.
module line_pixel_generator_test;
	timeunit 1ns;
	timeprecision 1ps;

	import lpg_pkg::*;

	localparam int IN_W = ((4*PIX_W + COLOR_W + 7)/8)*8;
	localparam int MAX_C = (1 << PIX_W) - 1;

	typedef struct {
		req_t              kind;
		logic [PIX_W-1:0]  sx, sy, ex, ey;
		logic [COLOR_W-1:0] color;
	} line_req_t;

	typedef struct {
		logic               pv;
		logic [PIX_W-1:0]   x, y;
		logic [ADDR_W-1:0]  addr;
		logic [COLOR_W-1:0] color;
		logic               last;
	} pixel_t;

	typedef enum {RX_FREE, RX_RANDOM, RX_SPARSE, RX_ALTERNATE} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic m_axis_tuser;
	logic m_axis_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [RW_W-1:0] cfg_data = '0;

	line_pixel_generator u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// line stepper state
	logic [PIX_W-1:0]   ln_x, ln_y, ln_major, ln_minor, ln_steps;
	logic [PIX_W:0]     ln_err;
	logic               ln_xneg, ln_yneg, ln_xmaj, ln_busy;
	logic [COLOR_W-1:0] ln_color;
	logic [RW_W-1:0]    row_w;

	line_req_t pending_reqs[$];
	pixel_t    expected_pixels[$];

	int errors = 0;
	int reqs_queued = 0, reqs_taken = 0, results_seen = 0;
	int n_starts = 0, n_steps = 0, n_idle = 0, n_ends = 0, n_widths = 0;
	logic req_taken = 1'b0, cfg_taken = 1'b0;
	bit hold_off_req = 0;
	int long_holds = 0;

	function automatic pixel_t rasterise(line_req_t r);
		pixel_t p;
		logic [PIX_W-1:0] adx, ady;
		logic [PIX_W+1:0] acc;
		p = '{default: '0};
		if (r.kind == REQ_START) begin
			ln_xneg = !(r.ex > r.sx);
			ln_yneg = !(r.ey > r.sy);
			adx = (r.ex > r.sx) ? r.ex - r.sx : r.sx - r.ex;
			ady = (r.ey > r.sy) ? r.ey - r.sy : r.sy - r.ey;
			ln_xmaj = adx > ady;
			ln_major = ln_xmaj ? adx : ady;
			ln_minor = ln_xmaj ? ady : adx;
			ln_err = {1'b0, ln_major} >> 1;
			ln_steps = ln_major;
			ln_x = r.sx;
			ln_y = r.sy;
			ln_color = r.color;
			ln_busy = ln_major != '0;
		end else if (!ln_busy) begin
			return p;
		end else begin
			acc = (PIX_W+2)'(ln_err) + (PIX_W+2)'(ln_minor);
			if (ln_xmaj) begin
				ln_x = ln_xneg ? ln_x - 1'b1 : ln_x + 1'b1;
				if (acc >= ln_major) begin
					acc = acc - ln_major;
					ln_y = ln_yneg ? ln_y - 1'b1 : ln_y + 1'b1;
				end
			end else begin
				ln_y = ln_yneg ? ln_y - 1'b1 : ln_y + 1'b1;
				if (acc >= ln_major) begin
					acc = acc - ln_major;
					ln_x = ln_xneg ? ln_x - 1'b1 : ln_x + 1'b1;
				end
			end
			ln_err = acc[PIX_W:0];
			ln_steps = ln_steps - 1'b1;
			if (ln_steps == '0)
				ln_busy = 1'b0;
		end
		p.pv = 1'b1;
		p.x = ln_x;
		p.y = ln_y;
		p.addr = ADDR_W'(32'(ln_y) * 32'(row_w) + 32'(ln_x));
		p.color = ln_color;
		p.last = !ln_busy;
		return p;
	endfunction

	task automatic report_mismatch(string msg);
		errors++;
		if (errors <= 60)
			$display("[%0t] MISMATCH pixel %0d: %s", $realtime, results_seen, msg);
	endtask

	task automatic check_pixel(pixel_t got, pixel_t want);
		if (got.pv !== want.pv)
			report_mismatch($sformatf("pixel_valid %0b want %0b", got.pv, want.pv));
		if (got.x !== want.x)
			report_mismatch($sformatf("pixel_x %0d want %0d", got.x, want.x));
		if (got.y !== want.y)
			report_mismatch($sformatf("pixel_y %0d want %0d", got.y, want.y));
		if (got.addr !== want.addr)
			report_mismatch($sformatf("pixel_address %0h want %0h", got.addr, want.addr));
		if (got.color !== want.color)
			report_mismatch($sformatf("pixel_color %0h want %0h", got.color, want.color));
		if (got.last !== want.last)
			report_mismatch($sformatf("last_pixel %0b want %0b", got.last, want.last));
	endtask

	// monitor: requests, config writes and pixels all sampled at the rising edge
	always @(posedge clk or negedge arst_n) begin
		pixel_t got;
		if (!arst_n) begin
			req_taken <= 1'b0;
			cfg_taken <= 1'b0;
		end else begin
			req_taken <= s_axis_tvalid && s_axis_tready;
			cfg_taken <= cfg_valid && cfg_ready;
			if (cfg_valid && cfg_ready)
				row_w = cfg_data;
			if (m_axis_tvalid && m_axis_tready) begin
				got.pv = m_axis_tuser;
				got.x = m_axis_tdata[PIX_W-1:0];
				got.y = m_axis_tdata[2*PIX_W-1:PIX_W];
				got.addr = m_axis_tdata[2*PIX_W+ADDR_W-1:2*PIX_W];
				got.color = m_axis_tdata[OUT_DATA_W-1:2*PIX_W+ADDR_W];
				got.last = m_axis_tlast;
				if (expected_pixels.size() == 0)
					report_mismatch("result with no request outstanding");
				else
					check_pixel(got, expected_pixels.pop_front());
				results_seen++;
				if (got.pv && got.last)
					n_ends++;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				expected_pixels.push_back(rasterise('{
					kind: req_t'(s_axis_tuser),
					sx: s_axis_tdata[PIX_W-1:0],
					sy: s_axis_tdata[2*PIX_W-1:PIX_W],
					ex: s_axis_tdata[3*PIX_W-1:2*PIX_W],
					ey: s_axis_tdata[4*PIX_W-1:3*PIX_W],
					color: s_axis_tdata[4*PIX_W+COLOR_W-1:4*PIX_W]}));
				reqs_taken++;
			end
		end
	end

	// request driver: bursts of random length with random gaps
	int burst_left = 0, gap_left = 0;
	always @(negedge clk) begin
		line_req_t r;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || req_taken) begin
			if (gap_left > 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				r = pending_reqs.pop_front();
				s_axis_tuser <= r.kind;
				s_axis_tdata <= IN_W'({r.color, r.ey, r.ex, r.sy, r.sx});
				s_axis_tvalid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// pixel receiver: stall pattern chosen per segment, plus a long hold-off on request
	rx_mode_t rx_mode = RX_FREE;
	int seg_left = 0, hold_left = 0;
	always @(negedge clk) begin
		if (hold_off_req) begin
			hold_off_req = 0;
			hold_left = 400;
			long_holds++;
		end
		if (seg_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			seg_left = $urandom_range(10, 80);
		end
		seg_left--;
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_FREE:      m_axis_tready <= 1'b1;
				RX_RANDOM:    m_axis_tready <= 1'($urandom_range(0, 1));
				RX_SPARSE:    m_axis_tready <= ($urandom_range(0, 7) != 0);
				RX_ALTERNATE: m_axis_tready <= ~m_axis_tready;
				default:      m_axis_tready <= 1'b1;
			endcase
		end
	end

	task automatic push_req(req_t kind, int sx, int sy, int ex, int ey, logic [31:0] color);
		pending_reqs.push_back('{kind: kind, sx: sx[PIX_W-1:0], sy: sy[PIX_W-1:0],
			ex: ex[PIX_W-1:0], ey: ey[PIX_W-1:0], color: color});
		reqs_queued++;
		if (kind == REQ_START)
			n_starts++;
		else
			n_steps++;
	endtask

	// a start followed by step requests; start fields of steps are random junk
	task automatic queue_line(int sx, int sy, int ex, int ey, logic [31:0] color, int n);
		push_req(REQ_START, sx, sy, ex, ey, color);
		repeat (n)
			push_req(REQ_STEP, $urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	function automatic int nearby(int c, int span);
		int v;
		v = c + int'($urandom_range(0, 2*span)) - span;
		if (v < 0)
			v = 0;
		if (v > MAX_C)
			v = MAX_C;
		return v;
	endfunction

	task automatic random_traffic(int count);
		int start_q, sx, sy, ex, ey, major, n, pick;
		start_q = reqs_queued;
		while (reqs_queued - start_q < count) begin
			pick = $urandom_range(0, 99);
			sx = $urandom_range(0, MAX_C);
			sy = $urandom_range(0, MAX_C);
			if (pick < 80) begin
				ex = nearby(sx, ($urandom_range(0, 4) == 0) ? 120 : 24);
				ey = nearby(sy, ($urandom_range(0, 4) == 0) ? 120 : 24);
			end else if (pick < 88) begin
				ex = $urandom_range(0, MAX_C);
				ey = $urandom_range(0, MAX_C);
			end else if (pick < 94) begin
				ex = ($urandom_range(0, 1) == 0) ? sx : nearby(sx, 20);
				ey = (ex == sx && $urandom_range(0, 2) != 0) ? sy : nearby(sy, 20);
				if (ex != sx && $urandom_range(0, 1) == 0)
					ey = sy;
			end else begin
				repeat ($urandom_range(1, 3))
					push_req(REQ_STEP, $urandom, $urandom, $urandom, $urandom, $urandom);
				continue;
			end
			major = (ex > sx) ? ex - sx : sx - ex;
			if (((ey > sy) ? ey - sy : sy - ey) > major)
				major = (ey > sy) ? ey - sy : sy - ey;
			if (pick >= 80 && pick < 88)
				n = $urandom_range(0, 24);
			else if ($urandom_range(0, 6) == 0)
				n = $urandom_range(0, major);
			else
				n = major + $urandom_range(0, 2);
			queue_line(sx, sy, ex, ey, $urandom, n);
		end
	endtask

	task automatic drain();
		while (reqs_taken != reqs_queued || expected_pixels.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_row_width(int w);
		@(negedge clk);
		cfg_data <= w[RW_W-1:0];
		cfg_valid <= 1'b1;
		do @(negedge clk); while (!cfg_taken);
		cfg_valid <= 1'b0;
		n_widths++;
	endtask

	initial begin
		row_w = RW_RESET;
		{ln_x, ln_y, ln_major, ln_minor, ln_steps, ln_err} = '0;
		{ln_xneg, ln_yneg, ln_xmaj, ln_busy} = '0;
		ln_color = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: step while idle, single-point line, diagonal, both directions,
		// abandoned lines, zero-length axis, full-range coordinates and colours
		push_req(REQ_STEP, MAX_C, MAX_C, MAX_C, MAX_C, 32'hFFFF_FFFF);
		queue_line(5, 5, 5, 5, 32'h0000_0000, 1);
		queue_line(0, 0, MAX_C, MAX_C, 32'hFFFF_FFFF, 3);
		queue_line(MAX_C, 0, 0, 3, 32'hA5A5_A5A5, 2);
		queue_line(10, 20, 8, 25, 32'h5A5A_5A5A, 5);
		queue_line(100, 100, 100, 96, 32'h1234_5678, 4);
		queue_line(MAX_C, MAX_C, MAX_C - 2, MAX_C, 32'h8000_0001, 2);
		random_traffic(230);
		drain();

		write_row_width(4096);
		hold_off_req = 1;
		queue_line(MAX_C, MAX_C, MAX_C - 3, MAX_C, 32'hDEAD_BEEF, 4);
		random_traffic(250);
		drain();

		write_row_width(1);
		random_traffic(250);
		drain();

		// widest value the register holds, so addresses wrap
		write_row_width((1 << RW_W) - 1);
		queue_line(MAX_C, MAX_C, MAX_C - 2, MAX_C - 1, 32'h0F0F_0F0F, 3);
		random_traffic(200);
		drain();

		write_row_width($urandom_range(2, 4095));
		random_traffic(250);
		drain();

		write_row_width($urandom_range(1, 4096));
		random_traffic(250);
		drain();

		write_row_width(RW_RESET);
		random_traffic(100);
		drain();

		if (expected_pixels.size() != 0)
			report_mismatch("pixels still outstanding at end of run");
		$display("Covered %0d requests (%0d starts, %0d steps) giving %0d results, %0d line ends.",
			reqs_taken, n_starts, n_steps, results_seen, n_ends);
		$display("Row width written %0d times; %0d long receiver hold-off(s); %0d mismatches.",
			n_widths, long_holds, errors);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Run timed out with %0d of %0d requests taken.", reqs_taken, reqs_queued);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
